// File: rtl/vpu_pkg.sv
// shared types and constants for the verlet position update block
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package vpu_pkg;

   // default position width, signed fixed point with 16 fraction bits
   localparam int POS_WIDTH_DEF = 32;

   // pipeline depth of the datapath
   localparam int STAGES = 5;

   // register field widths
   localparam int FRICTION_W = 16;
   localparam int TSTEP_W    = 16;
   localparam int MODE_W     = 2;
   localparam int WORLD_W    = 31;
   localparam int DAMP_W     = 17;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   // reset values of the registers
   localparam logic [FRICTION_W-1:0] FRICTION_RST = 16'd0;
   localparam logic [TSTEP_W-1:0]    TSTEP_RST    = 16'd1092;
   localparam logic [WORLD_W-1:0]    WORLD_RST    = 31'd67108864;
   localparam logic [TSTEP_W-1:0]    DT2_RST      = TSTEP_W'((1092 * 1092) >> 16);
   localparam logic [DAMP_W-1:0]     DAMP_ONE     = 17'd65536;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_FRICTION     = 3'd0,
      REG_TIME_STEP    = 3'd1,
      REG_BOUNDARY     = 3'd2,
      REG_WORLD_WIDTH  = 3'd3,
      REG_WORLD_HEIGHT = 3'd4
   } reg_index_type;

   typedef enum logic [MODE_W-1:0] {
      BMODE_BOUNCE = 2'd0,
      BMODE_WRAP   = 2'd1,
      BMODE_OPEN   = 2'd2
   } bmode_type;

   // settings shared by both axes
   typedef struct packed {
      logic [DAMP_W-1:0]  damp;   // 1 - friction, Q1.16
      logic [TSTEP_W-1:0] dt2;    // dt squared, Q0.16
      logic [MODE_W-1:0]  mode;
   } cfg_type;

endpackage

// File: rtl/verlet_position_update.sv
// top level of the damped verlet position update with boundary handling
// depends on vpu_pkg and vpu_axis
`timescale 1ns / 1ps

// Takes one particle per request (current, previous position and accumulated
// acceleration, all signed fixed point with 16 fraction bits) and returns its
// new position and new previous position after the boundary rule, plus a flag
// that is set when any add or subtract clipped to the position range. Both
// axes run side by side through a five-stage pipeline (difference, products,
// velocity sum, position sum, boundary), so one request is taken every clock
// while the output side is not stalled, and its response leaves from the last
// stage; the per-axis multipliers in stage two set the cycle time. Each
// stage holds its own valid bit and frees up as soon as its content moves
// on, so empty stages are filled even while a response waits on rsp_tready.
// Registers are written through the csr port, which is always ready; they
// are to be changed only while no request is in flight.

module verlet_position_update
   import vpu_pkg::*;
#(
   parameter int POS_WIDTH = POS_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          req_tvalid,
   output logic                          req_tready,
   // cur_x, cur_y, old_x, old_y, accel_x, accel_y from bit 0 up, zero fill
   input  logic [((6*POS_WIDTH+7)/8)*8-1:0] req_tdata,

   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // next_x, next_y, back_x, back_y from bit 0 up, zero fill
   output logic [((4*POS_WIDTH+7)/8)*8-1:0] rsp_tdata,
   // saturated
   output logic                          rsp_tuser,

   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CSR_INDEX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]         csr_wdata
);

   localparam int P        = POS_WIDTH;
   localparam int RSP_W    = ((4*P+7)/8)*8;
   localparam int CW       = (P-1 > WORLD_W) ? P-1 : WORLD_W;
   localparam logic [CW-1:0] PMAX_EXT = CW'({(P-1){1'b1}});

   // configuration registers
   logic [FRICTION_W-1:0] friction_ff;
   logic [TSTEP_W-1:0]    time_step_ff;
   logic [MODE_W-1:0]     mode_ff;
   logic [WORLD_W-1:0]    world_w_ff, world_h_ff;
   logic [TSTEP_W-1:0]    dt2_ff;
   logic [2*TSTEP_W-1:0]  dt2_prod;
   cfg_type               cfg;

   // world sizes clipped to the largest position
   logic [CW-1:0]         world_w_ext, world_h_ext;
   logic [P-2:0]          world_x, world_y;

   // pipeline control
   logic [STAGES-1:0]     v_ff;
   logic [STAGES-1:0]     en;

   // payload
   logic signed [P-1:0]   cur_x, cur_y, old_x, old_y, accel_x, accel_y;
   logic signed [P-1:0]   next_x, next_y, back_x, back_y;
   logic                  sat_x, sat_y;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         friction_ff  <= FRICTION_RST;
         time_step_ff <= TSTEP_RST;
         mode_ff      <= BMODE_BOUNCE;
         world_w_ff   <= WORLD_RST;
         world_h_ff   <= WORLD_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_FRICTION:     friction_ff  <= csr_wdata[FRICTION_W-1:0];
            REG_TIME_STEP:    time_step_ff <= csr_wdata[TSTEP_W-1:0];
            REG_BOUNDARY:     mode_ff      <= csr_wdata[MODE_W-1:0];
            REG_WORLD_WIDTH:  world_w_ff   <= csr_wdata[WORLD_W-1:0];
            REG_WORLD_HEIGHT: world_h_ff   <= csr_wdata[WORLD_W-1:0];
            default: begin
               // writes beyond the register list are dropped
            end
         endcase
      end
   end

   // dt squared is registered and follows the time step in the next cycle
   assign dt2_prod = time_step_ff * time_step_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dt2_ff <= DT2_RST;
      end else begin
         dt2_ff <= dt2_prod[2*TSTEP_W-1:TSTEP_W];
      end
   end

   assign cfg.damp = DAMP_ONE - DAMP_W'(friction_ff);
   assign cfg.dt2  = dt2_ff;
   assign cfg.mode = mode_ff;

   assign world_w_ext = CW'(world_w_ff);
   assign world_h_ext = CW'(world_h_ff);
   assign world_x = (world_w_ext > PMAX_EXT) ? PMAX_EXT[P-2:0] : world_w_ext[P-2:0];
   assign world_y = (world_h_ext > PMAX_EXT) ? PMAX_EXT[P-2:0] : world_h_ext[P-2:0];

   // a stage may load when it is empty or its content moves on
   always_comb begin
      en[STAGES-1] = !v_ff[STAGES-1] || rsp_tready;
      for (int i = STAGES-2; i >= 0; i--) begin
         en[i] = !v_ff[i] || en[i+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) begin
            v_ff[0] <= req_tvalid;
         end
         for (int i = 1; i < STAGES; i++) begin
            if (en[i]) begin
               v_ff[i] <= v_ff[i-1];
            end
         end
      end
   end

   assign req_tready = en[0];

   // request unpacking
   assign cur_x   = req_tdata[0*P +: P];
   assign cur_y   = req_tdata[1*P +: P];
   assign old_x   = req_tdata[2*P +: P];
   assign old_y   = req_tdata[3*P +: P];
   assign accel_x = req_tdata[4*P +: P];
   assign accel_y = req_tdata[5*P +: P];

   vpu_axis #(
      .POS_WIDTH (POS_WIDTH)
   ) u_axis_x (
      .clock    (clock),
      .en       (en),
      .cfg      (cfg),
      .world    (world_x),
      .cur      (cur_x),
      .old      (old_x),
      .acc      (accel_x),
      .next_out (next_x),
      .back_out (back_x),
      .sat_out  (sat_x)
   );

   vpu_axis #(
      .POS_WIDTH (POS_WIDTH)
   ) u_axis_y (
      .clock    (clock),
      .en       (en),
      .cfg      (cfg),
      .world    (world_y),
      .cur      (cur_y),
      .old      (old_y),
      .acc      (accel_y),
      .next_out (next_y),
      .back_out (back_y),
      .sat_out  (sat_y)
   );

   // response packing, last stage is the output register
   assign rsp_tvalid = v_ff[STAGES-1];
   assign rsp_tdata  = RSP_W'({back_y, back_x, next_y, next_x});
   assign rsp_tuser  = sat_x | sat_y;

endmodule

// File: rtl/vpu_axis.sv
// one axis of the verlet update: five register stages from positions to bounded result
// depends on vpu_pkg
`timescale 1ns / 1ps

module vpu_axis
   import vpu_pkg::*;
#(
   parameter int POS_WIDTH = POS_WIDTH_DEF
) (
   input  logic                        clock,
   input  logic [STAGES-1:0]           en,
   input  cfg_type                     cfg,
   input  logic [POS_WIDTH-2:0]        world,
   input  logic signed [POS_WIDTH-1:0] cur,
   input  logic signed [POS_WIDTH-1:0] old,
   input  logic signed [POS_WIDTH-1:0] acc,
   output logic signed [POS_WIDTH-1:0] next_out,
   output logic signed [POS_WIDTH-1:0] back_out,
   output logic                        sat_out
);

   localparam int P = POS_WIDTH;
   localparam logic [P-1:0] PMAX = {1'b0, {(P-1){1'b1}}};
   localparam logic [P-1:0] PMIN = {1'b1, {(P-1){1'b0}}};

   function automatic logic [P:0] sat_add(input logic signed [P-1:0] a,
                                          input logic signed [P-1:0] b);
      logic signed [P:0] s;
      s = {a[P-1], a} + {b[P-1], b};
      if (s[P] != s[P-1]) begin
         return {1'b1, (s[P] ? PMIN : PMAX)};
      end
      return {1'b0, s[P-1:0]};
   endfunction

   function automatic logic [P:0] sat_sub(input logic signed [P-1:0] a,
                                          input logic signed [P-1:0] b);
      logic signed [P:0] s;
      s = {a[P-1], a} - {b[P-1], b};
      if (s[P] != s[P-1]) begin
         return {1'b1, (s[P] ? PMIN : PMAX)};
      end
      return {1'b0, s[P-1:0]};
   endfunction

   // stage 1: difference
   logic signed [P-1:0] diff1_ff, cur1_ff, acc1_ff;
   logic                sat1_ff;
   logic [P:0]          diff1_in;

   // stage 2: products
   logic signed [P-1:0] vel2_ff, acct2_ff, cur2_ff;
   logic                sat2_ff;
   logic signed [P+17:0] vprod;
   logic signed [P+16:0] aprod;

   // stage 3: velocity plus acceleration term
   logic signed [P-1:0] sum3_ff, vel3_ff, cur3_ff;
   logic                sat3_ff;
   logic [P:0]          sum3_in;

   // stage 4: new position
   logic signed [P-1:0] nxt4_ff, vel4_ff, cur4_ff;
   logic                sat4_ff;
   logic [P:0]          nxt4_in;

   // stage 5: boundary rule
   logic signed [P-1:0] next5_ff, back5_ff;
   logic                sat5_ff;
   logic signed [P-1:0] next5_in, back5_in;
   logic                sat5_in;
   logic signed [P-1:0] w_s;
   logic [P:0]          t_nxt, t_back;

   assign diff1_in = sat_sub(cur, old);

   always_ff @(posedge clock) begin
      if (en[0]) begin
         diff1_ff <= diff1_in[P-1:0];
         sat1_ff  <= diff1_in[P];
         cur1_ff  <= cur;
         acc1_ff  <= acc;
      end
   end

   // both scale factors are at most one, so the products never grow
   assign vprod = diff1_ff * $signed({1'b0, cfg.damp});
   assign aprod = acc1_ff * $signed({1'b0, cfg.dt2});

   always_ff @(posedge clock) begin
      if (en[1]) begin
         vel2_ff  <= vprod[P+15:16];
         acct2_ff <= aprod[P+15:16];
         cur2_ff  <= cur1_ff;
         sat2_ff  <= sat1_ff;
      end
   end

   assign sum3_in = sat_add(vel2_ff, acct2_ff);

   always_ff @(posedge clock) begin
      if (en[2]) begin
         sum3_ff <= sum3_in[P-1:0];
         vel3_ff <= vel2_ff;
         cur3_ff <= cur2_ff;
         sat3_ff <= sat2_ff | sum3_in[P];
      end
   end

   assign nxt4_in = sat_add(cur3_ff, sum3_ff);

   always_ff @(posedge clock) begin
      if (en[3]) begin
         nxt4_ff <= nxt4_in[P-1:0];
         vel4_ff <= vel3_ff;
         cur4_ff <= cur3_ff;
         sat4_ff <= sat3_ff | nxt4_in[P];
      end
   end

   assign w_s = {1'b0, world};

   always_comb begin
      next5_in = nxt4_ff;
      back5_in = cur4_ff;
      sat5_in  = sat4_ff;
      t_nxt    = '0;
      t_back   = '0;
      case (cfg.mode)
         BMODE_BOUNCE: begin
            if (nxt4_ff[P-1]) begin
               next5_in = '0;
               back5_in = vel4_ff;
            end else if (nxt4_ff > w_s) begin
               t_back   = sat_add(w_s, vel4_ff);
               next5_in = w_s;
               back5_in = t_back[P-1:0];
               sat5_in  = sat4_ff | t_back[P];
            end
         end
         BMODE_WRAP: begin
            if (nxt4_ff[P-1]) begin
               t_nxt    = sat_add(nxt4_ff, w_s);
               t_back   = sat_add(cur4_ff, w_s);
               next5_in = t_nxt[P-1:0];
               back5_in = t_back[P-1:0];
               sat5_in  = sat4_ff | t_nxt[P] | t_back[P];
            end else if (nxt4_ff >= w_s) begin
               t_nxt    = sat_sub(nxt4_ff, w_s);
               t_back   = sat_sub(cur4_ff, w_s);
               next5_in = t_nxt[P-1:0];
               back5_in = t_back[P-1:0];
               sat5_in  = sat4_ff | t_nxt[P] | t_back[P];
            end
         end
         default: begin
            // open edges and the unused code leave the result alone
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en[4]) begin
         next5_ff <= next5_in;
         back5_ff <= back5_in;
         sat5_ff  <= sat5_in;
      end
   end

   assign next_out = next5_ff;
   assign back_out = back5_ff;
   assign sat_out  = sat5_ff;

endmodule

// File: rtl/vpu_checker.sv
// port-level checks for the verlet position update, bound to the top level
// depends on vpu_pkg and verlet_position_update
`timescale 1ns / 1ps

module vpu_checker
   import vpu_pkg::*;
#(
   parameter int POS_WIDTH = POS_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   input  logic                          req_tready,
   input  logic [((6*POS_WIDTH+7)/8)*8-1:0] req_tdata,
   input  logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   input  logic [((4*POS_WIDTH+7)/8)*8-1:0] rsp_tdata,
   input  logic                          rsp_tuser,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [CSR_INDEX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]         csr_wdata
);

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   // an empty output stage means nothing can block the input
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request refused with an empty output stage");

   // a free-running output keeps the input open
   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      rsp_tready |-> req_tready)
      else $error("request refused although responses drain");

   // a stalled response holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

endmodule

bind verlet_position_update vpu_checker #(.POS_WIDTH(POS_WIDTH)) u_vpu_checker (.*);
